/* hw/rtl/v3n_pkg.sv */
// Package for the 3D vector normalizer.
// Holds the default parameter values and the pipeline control type; no dependencies.
`default_nettype none

package v3n_pkg;

    // Default component width and number of fraction bits of the result.
    localparam int IN_WIDTH_DEF  = 24;
    localparam int FRAC_BITS_DEF = 22;

    // Control that travels alongside each vector through the pipeline.
    typedef struct packed {
        logic       valid;
        logic       zero;
        logic [2:0] neg;
    } t_ctl;

endpackage

`default_nettype wire

/* hw/rtl/v3n_if.sv */
// Request channels of the 3D vector normalizer: input vector and unit result.
// Uses no package; widths come from parameters.
`default_nettype none

interface v3n_in_if #(
    parameter int IN_WIDTH = 24
);
    logic                       valid;
    logic                       ready;
    logic signed [IN_WIDTH-1:0] comp_x;
    logic signed [IN_WIDTH-1:0] comp_y;
    logic signed [IN_WIDTH-1:0] comp_z;

    modport source (output valid, comp_x, comp_y, comp_z, input ready);
    modport sink   (input valid, comp_x, comp_y, comp_z, output ready);
endinterface

interface v3n_out_if #(
    parameter int OUT_WIDTH = 24
);
    logic                        valid;
    logic                        ready;
    logic signed [OUT_WIDTH-1:0] unit_x;
    logic signed [OUT_WIDTH-1:0] unit_y;
    logic signed [OUT_WIDTH-1:0] unit_z;
    logic                        was_zero;

    modport source (output valid, unit_x, unit_y, unit_z, was_zero, input ready);
    modport sink   (input valid, unit_x, unit_y, unit_z, was_zero, output ready);
endinterface

`default_nettype wire

/* hw/rtl/v3n_root_step.sv */
// One bit of the inverse square root search for one component.
// Decides result bit B by an add and compare; depends on nothing else.
`default_nettype none

module v3n_root_step #(
    parameter int PW = 94,
    parameter int QW = 23,
    parameter int B  = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [PW-1:0] i_s,
    input  wire logic [PW-1:0] i_r,
    input  wire logic [PW-1:0] i_p,
    input  wire logic [PW-1:0] i_qs,
    input  wire logic [QW-1:0] i_q,
    output logic      [PW-1:0] o_s,
    output logic      [PW-1:0] o_r,
    output logic      [PW-1:0] o_p,
    output logic      [PW-1:0] o_qs,
    output logic      [QW-1:0] o_q
);
    logic [PW-1:0] cand;
    logic          take;
    logic [PW-1:0] r_s, r_r, r_p, r_qs;
    logic [QW-1:0] r_q;
    logic [PW-1:0] n_p, n_qs;
    logic [QW-1:0] n_q;

    // With t = q + 2^B, t*t*S = q*q*S + 2^(B+1)*q*S + 2^(2B)*S.
    assign cand = i_p + (i_qs << (B + 1)) + (i_s << (2 * B));
    assign take = (cand <= i_r);

    always_comb begin
        n_p  = take ? cand : i_p;
        n_qs = take ? (i_qs + (i_s << B)) : i_qs;
        n_q  = i_q | (QW'(take) << B);
    end

    // Stage register, held while the pipeline is stalled.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s  <= i_s;
            r_r  <= i_r;
            r_p  <= n_p;
            r_qs <= n_qs;
            r_q  <= n_q;
        end
    end

    assign o_s  = r_s;
    assign o_r  = r_r;
    assign o_p  = r_p;
    assign o_qs = r_qs;
    assign o_q  = r_q;
endmodule

`default_nettype wire

/* hw/rtl/vector3_normalize_top.sv */
// Normalizes a signed 3D vector to a unit vector in signed Q1.FRAC_BITS.
// One vector enters per cycle while the output is not stalled.
// Three stages take magnitudes, squares and the length sum, then one stage per result bit.
// A stalled output holds the whole pipeline; nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits; data registers are not reset.
// Depends on v3n_pkg, v3n_if and v3n_root_step.
`default_nettype none

module vector3_normalize_top
    import v3n_pkg::*;
#(
    parameter int IN_WIDTH  = IN_WIDTH_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    v3n_in_if.sink    i_vec,
    v3n_out_if.source o_unit
);
    localparam int W   = IN_WIDTH;
    localparam int PW  = 2 * IN_WIDTH + 2 * FRAC_BITS + 2;
    localparam int QW  = FRAC_BITS + 1;
    localparam int OW  = FRAC_BITS + 2;
    localparam int NST = FRAC_BITS + 1;

    logic en;
    logic [W-1:0] comp [3];

    // Stage 0: magnitudes and signs.
    logic [W-1:0]    r_mag [3];
    t_ctl            r_ctl0;
    // Stage 1: squares.
    logic [2*W-1:0]  r_sq [3];
    t_ctl            r_ctl1;
    // Stage 2 onward: search state per lane.
    logic [PW-1:0]   s_a  [NST+1][3];
    logic [PW-1:0]   r_a  [NST+1][3];
    logic [PW-1:0]   p_a  [NST+1][3];
    logic [PW-1:0]   qs_a [NST+1][3];
    logic [QW-1:0]   q_a  [NST+1][3];
    t_ctl            r_ctl [NST+1];
    logic [PW-1:0]   r_s2;
    logic [PW-1:0]   r_r2 [3];
    // Output register.
    logic [OW-1:0]   r_unit [3];
    logic            r_zero;
    logic            r_out_vld;

    // The pipeline advances whenever the output register is free or being taken.
    assign en          = !r_out_vld || o_unit.ready;
    assign i_vec.ready = en;

    assign comp[0] = i_vec.comp_x;
    assign comp[1] = i_vec.comp_y;
    assign comp[2] = i_vec.comp_z;

    // Stage 0: two's complement magnitude; the most negative value maps to 2^(W-1).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
        end else if (en) begin
            r_ctl0.valid <= i_vec.valid;
            r_ctl0.zero  <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_ctl0.neg[i] <= comp[i][W-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_mag[i] <= comp[i][W-1] ? (~comp[i] + W'(1)) : comp[i];
            end
        end
    end

    // Stage 1: one multiplier per component.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
        end else if (en) begin
            r_ctl1 <= r_ctl0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= r_mag[i] * r_mag[i];
            end
        end
    end

    // Stage 2: squared length, scaled targets and the zero check.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else if (en) begin
            r_ctl[0].valid <= r_ctl1.valid;
            r_ctl[0].neg   <= r_ctl1.neg;
            r_ctl[0].zero  <= (r_sq[0] == '0) && (r_sq[1] == '0) && (r_sq[2] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2 <= PW'(r_sq[0]) + PW'(r_sq[1]) + PW'(r_sq[2]);
            for (int i = 0; i < 3; i++) begin
                r_r2[i] <= PW'(r_sq[i]) << (2 * FRAC_BITS);
            end
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_init
        assign s_a[0][l]  = r_s2;
        assign r_a[0][l]  = r_r2[l];
        assign p_a[0][l]  = '0;
        assign qs_a[0][l] = '0;
        assign q_a[0][l]  = '0;
    end

    // One stage per result bit, most significant first.
    for (genvar k = 0; k < NST; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k+1] <= '0;
            end else if (en) begin
                r_ctl[k+1] <= r_ctl[k];
            end
        end

        for (genvar l = 0; l < 3; l++) begin : g_lane
            v3n_root_step #(
                .PW (PW),
                .QW (QW),
                .B  (FRAC_BITS - k)
            ) u_step (
                .i_clk (i_clk),
                .i_en  (en),
                .i_s   (s_a[k][l]),
                .i_r   (r_a[k][l]),
                .i_p   (p_a[k][l]),
                .i_qs  (qs_a[k][l]),
                .i_q   (q_a[k][l]),
                .o_s   (s_a[k+1][l]),
                .o_r   (r_a[k+1][l]),
                .o_p   (p_a[k+1][l]),
                .o_qs  (qs_a[k+1][l]),
                .o_q   (q_a[k+1][l])
            );
        end
    end

    // Output stage: apply signs, force zero for a zero-length vector.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_ctl[NST].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zero <= r_ctl[NST].zero;
            for (int i = 0; i < 3; i++) begin
                if (r_ctl[NST].zero) begin
                    r_unit[i] <= '0;
                end else if (r_ctl[NST].neg[i]) begin
                    r_unit[i] <= ~OW'(q_a[NST][i]) + OW'(1);
                end else begin
                    r_unit[i] <= OW'(q_a[NST][i]);
                end
            end
        end
    end

    assign o_unit.valid    = r_out_vld;
    assign o_unit.unit_x   = r_unit[0];
    assign o_unit.unit_y   = r_unit[1];
    assign o_unit.unit_z   = r_unit[2];
    assign o_unit.was_zero = r_zero;

`ifndef SYNTHESIS
    localparam logic signed [OW-1:0] ONE = OW'(1) << FRAC_BITS;

    // A zero-length vector always gives zero components.
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_unit.valid && o_unit.was_zero) |->
        (o_unit.unit_x == '0 && o_unit.unit_y == '0 && o_unit.unit_z == '0))
        else $error("zero vector gave nonzero components");

    // Results never exceed unit magnitude.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_unit.valid |->
        (o_unit.unit_x <= ONE && o_unit.unit_x >= -ONE &&
         o_unit.unit_y <= ONE && o_unit.unit_y >= -ONE &&
         o_unit.unit_z <= ONE && o_unit.unit_z >= -ONE))
        else $error("unit component out of range");

    // Nothing is presented right after reset.
    a_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_unit.valid)
        else $error("result valid after reset");
`endif

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for vector3_normalize_top: random and directed vectors,
// predicted unit vectors compared field by field. Depends on v3n_pkg and v3n_if.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import v3n_pkg::*;

    localparam int IW  = IN_WIDTH_DEF;
    localparam int FB  = FRAC_BITS_DEF;
    localparam int OW  = FB + 2;
    localparam int LATENCY = FB + 5;
    localparam longint CYCLE_LIMIT = 200000;

    typedef struct {
        logic signed [IW-1:0] x, y, z;
    } t_vec;

    typedef struct {
        logic signed [OW-1:0] ux, uy, uz;
        logic                 zero;
    } t_unit;

    logic i_clk;
    logic i_rst_n;

    v3n_in_if  #(.IN_WIDTH(IW)) vec_ch ();
    v3n_out_if #(.OUT_WIDTH(OW)) unit_ch ();

    vector3_normalize_top #(.IN_WIDTH(IW), .FRAC_BITS(FB)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vec  (vec_ch.sink),
        .o_unit (unit_ch.source)
    );

    // Clock generation.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    t_vec   pending_vecs[$];
    t_unit  expected_units[$];
    int     errors = 0;
    int     sent = 0;
    int     received = 0;
    int     zero_seen = 0;
    longint cycles = 0;
    bit     hold_sender = 1'b0;
    bit     stim_done = 1'b0;
    bit     in_taken = 1'b0;
    int     rx_wait = 0;

    // Largest q with q*q*sum <= mag*mag*2^(2*FB), built one bit at a time.
    function automatic logic [FB:0] root_bits(logic [IW:0] mag, logic [2*IW+1:0] sum);
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [FB:0]  q;
        logic [FB:0]  t;
        rhs = (128'(mag) * 128'(mag)) << (2 * FB);
        q = '0;
        for (int b = FB; b >= 0; b--) begin
            t = q | ((FB+1)'(1) << b);
            lhs = 128'(t) * 128'(t) * 128'(sum);
            if (lhs <= rhs) q = t;
        end
        return q;
    endfunction

    // Expected unit vector for one input vector.
    function automatic t_unit normalize_vec(t_vec v);
        t_unit r;
        logic [IW:0]      m[3];
        logic             n[3];
        logic [2*IW+1:0]  sum;
        logic signed [IW-1:0] c[3];
        logic signed [OW-1:0] u[3];
        c[0] = v.x; c[1] = v.y; c[2] = v.z;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            n[i] = c[i][IW-1];
            m[i] = n[i] ? (IW+1)'(-$signed({c[i][IW-1], c[i]})) : (IW+1)'(c[i]);
            sum += (2*IW+2)'(m[i]) * (2*IW+2)'(m[i]);
        end
        if (sum == 0) begin
            r.ux = '0; r.uy = '0; r.uz = '0; r.zero = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++) begin
            u[i] = OW'(root_bits(m[i], sum));
            if (n[i]) u[i] = -u[i];
        end
        r.ux = u[0]; r.uy = u[1]; r.uz = u[2]; r.zero = 1'b0;
        return r;
    endfunction

    function automatic logic signed [IW-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return IW'($urandom_range(0, 15)) - IW'(8);
            1: return {1'b1, {(IW-1){1'b0}}};
            2: return {1'b0, {(IW-1){1'b1}}};
            default: return IW'($urandom);
        endcase
    endfunction

    function automatic t_vec mk(int x, int y, int z);
        t_vec v;
        v.x = IW'(x); v.y = IW'(y); v.z = IW'(z);
        return v;
    endfunction

    // Driver: inputs change on the falling edge; a random gap follows each request.
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            vec_ch.valid <= 1'b0;
        end else if (vec_ch.valid && !in_taken) begin
            // Request still waiting for acceptance.
        end else if (gap_left > 0) begin
            vec_ch.valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_vecs.size() > 0 && !hold_sender) begin
            t_vec v;
            v = pending_vecs.pop_front();
            vec_ch.valid  <= 1'b1;
            vec_ch.comp_x <= v.x;
            vec_ch.comp_y <= v.y;
            vec_ch.comp_z <= v.z;
            expected_units.push_back(normalize_vec(v));
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        end else begin
            vec_ch.valid <= 1'b0;
        end
        // Receiver waits the drawn number of cycles after each result it takes.
        if (rx_wait > 0) begin
            unit_ch.ready <= 1'b0;
            rx_wait <= rx_wait - 1;
        end else begin
            unit_ch.ready <= 1'b1;
        end
    end

    // Monitor: samples both channels on the rising edge.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        in_taken <= i_rst_n && vec_ch.valid && vec_ch.ready;
        if (i_rst_n && vec_ch.valid && vec_ch.ready) sent <= sent + 1;
        if (i_rst_n && unit_ch.valid && unit_ch.ready) begin
            received <= received + 1;
            // Stretches with no receiver wait, otherwise a random wait per result.
            rx_wait <= (cycles % 4000 < 1000) ? 0 : $urandom_range(0, 7);
            if (unit_ch.was_zero) zero_seen <= zero_seen + 1;
            if (expected_units.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d z=%0d zero=%0b", $realtime,
                         unit_ch.unit_x, unit_ch.unit_y, unit_ch.unit_z, unit_ch.was_zero);
                errors <= errors + 1;
            end else begin
                t_unit e;
                e = expected_units.pop_front();
                if (unit_ch.unit_x !== e.ux || unit_ch.unit_y !== e.uy ||
                    unit_ch.unit_z !== e.uz || unit_ch.was_zero !== e.zero) begin
                    $display("%0t: mismatch expected x=%0d y=%0d z=%0d zero=%0b",
                             $realtime, e.ux, e.uy, e.uz, e.zero);
                    $display("%0t:          actual   x=%0d y=%0d z=%0d zero=%0b",
                             $realtime, unit_ch.unit_x, unit_ch.unit_y, unit_ch.unit_z,
                             unit_ch.was_zero);
                    errors <= errors + 1;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout", $realtime);
            $display("** vector3_normalize_top: FAILED **");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial begin
        int max_c;
        max_c = 8388607;
        i_rst_n = 1'b0;
        vec_ch.valid = 1'b0;
        vec_ch.comp_x = '0;
        vec_ch.comp_y = '0;
        vec_ch.comp_z = '0;
        unit_ch.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: zero vector, axis vectors, extremes, mixed signs.
        pending_vecs.push_back(mk(0, 0, 0));
        pending_vecs.push_back(mk(1, 0, 0));
        pending_vecs.push_back(mk(0, -1, 0));
        pending_vecs.push_back(mk(0, 0, max_c));
        pending_vecs.push_back(mk(-max_c - 1, 0, 0));
        pending_vecs.push_back(mk(0, -max_c - 1, 0));
        pending_vecs.push_back(mk(0, 0, -max_c - 1));
        pending_vecs.push_back(mk(-max_c - 1, -max_c - 1, -max_c - 1));
        pending_vecs.push_back(mk(max_c, max_c, max_c));
        pending_vecs.push_back(mk(max_c, -max_c - 1, max_c));
        pending_vecs.push_back(mk(1, 1, 1));
        pending_vecs.push_back(mk(-1, -1, -1));
        pending_vecs.push_back(mk(3, 4, 0));
        pending_vecs.push_back(mk(2, -3, 6));
        pending_vecs.push_back(mk(1, max_c, 0));
        pending_vecs.push_back(mk(-1, 0, -max_c - 1));
        pending_vecs.push_back(mk(0, 0, 0));

        // Let the directed part drain fully before the random part.
        wait (pending_vecs.size() == 0);
        hold_sender = 1'b1;
        wait (expected_units.size() == 0 && vec_ch.valid == 1'b0);
        hold_sender = 1'b0;

        for (int i = 0; i < 850; i++) begin
            t_vec v;
            v.x = rand_comp();
            v.y = rand_comp();
            v.z = rand_comp();
            if ($urandom_range(0, 40) == 0) v = mk(0, 0, 0);
            pending_vecs.push_back(v);
        end

        wait (pending_vecs.size() == 0);
        wait (expected_units.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("Sent %0d vectors and checked %0d unit results (%0d zero-length).",
                 sent, received, zero_seen);
        if (errors == 0 && expected_units.size() == 0) begin
            $display("** vector3_normalize_top: PASSED **");
        end else begin
            $display("** vector3_normalize_top: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
